>>> hdl/canary_shadow_stack_unit_defines.svh
// assertion macros used by the shadow stack core
`ifndef CANARY_SHADOW_STACK_UNIT_DEFINES_SVH
`define CANARY_SHADOW_STACK_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define CSS_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define CSS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/css_pkg.sv
// shared types and constants of the canary shadow stack
`timescale 1ns / 1ps

package css_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned DEPTH_OUT_W = 11;
  localparam int unsigned REG_IDX_W   = 1;

  // command codes
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SEED   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COOKIE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_MISMATCH  = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // one result word
  typedef struct packed {
    status_t                  status;
    logic [DATA_W-1:0]        canary;
    logic [DATA_W-1:0]        expected;
    logic [DEPTH_OUT_W-1:0]   depth;
  } result_t;

  // request from the control logic to the entry memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> hdl/css_if.sv
// valid/ready channel interfaces for command and result words
`timescale 1ns / 1ps

interface css_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] func_ident;
  logic [63:0] presented_canary;

  modport source (output valid, output command, output func_ident,
                  output presented_canary, input ready);
  modport sink   (input valid, input command, input func_ident,
                  input presented_canary, output ready);
endinterface

interface css_out_if;
  logic             valid;
  logic             ready;
  css_pkg::status_t status;
  logic [63:0]      canary_out;
  logic [63:0]      expected_out;
  logic [10:0]      depth_out;

  modport source (output valid, output status, output canary_out,
                  output expected_out, output depth_out, input ready);
  modport sink   (input valid, input status, input canary_out,
                  input expected_out, input depth_out, output ready);
endinterface

>>> hdl/css_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`timescale 1ns / 1ps

module css_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, read data registered while re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/css_core.sv
// control, config registers, call counter and result buffering of the shadow stack
`timescale 1ns / 1ps
`include "canary_shadow_stack_unit_defines.svh"

module css_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        write_enable,
  input  logic [css_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [css_pkg::DATA_W-1:0]  write_data,
  css_in_if.sink                      in_ch,
  css_out_if.source                   out_ch,
  output css_pkg::mem_req_t           mem_req,
  input  logic [css_pkg::DATA_W-1:0]  mem_rdata
);
  import css_pkg::*;

  state_t              state;
  state_t              state_next;
  logic [DATA_W-1:0]   seed;
  logic [DATA_W-1:0]   cookie;
  logic [DATA_W-1:0]   call_count;
  logic [CNT_W-1:0]    top;
  logic [CNT_W-1:0]    top_next;
  logic [DATA_W-1:0]   presented;

  logic                accept;
  logic                is_push;
  logic                full;
  logic                empty;
  logic [CNT_W-1:0]    top_inc;
  logic [CNT_W-1:0]    top_dec;
  logic [DATA_W-1:0]   count_inc;
  logic [DATA_W-1:0]   canary;
  logic [DATA_W-1:0]   expected;

  logic                gen_valid;
  result_t             gen_result;
  logic                out_valid;
  result_t             out_data;
  logic                hold_valid;
  result_t             hold_data;
  logic                out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      seed   <= '0;
      cookie <= '0;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_SEED:   seed   <= write_data;
        REG_COOKIE: cookie <= write_data;
        default:    ;
      endcase
    end
  end

  // handshake and stack pointer arithmetic
  assign in_ch.ready = (state == ST_IDLE) && !hold_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.command == CMD_PUSH);
  assign full        = (top == CNT_W'(STACK_DEPTH));
  assign empty       = (top == '0);
  assign top_inc     = top + CNT_W'(1);
  assign top_dec     = top - CNT_W'(1);
  assign count_inc   = call_count + DATA_W'(1);
  assign canary      = seed ^ in_ch.func_ident ^ count_inc;
  assign expected    = mem_rdata ^ cookie;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && !is_push && !empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory requests, stack pointer update and result forming
  always_comb begin
    mem_req          = '0;
    mem_req.waddr    = top[ADDR_W-1:0];
    mem_req.wdata    = canary ^ cookie;
    mem_req.raddr    = top_dec[ADDR_W-1:0];
    top_next         = top;
    gen_valid        = 1'b0;
    gen_result       = '0;
    gen_result.depth = DEPTH_OUT_W'(top);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          gen_valid = is_push || empty;
          if (is_push) begin
            gen_result.canary = canary;
            if (full) begin
              gen_result.status = STATUS_OVERFLOW;
            end else begin
              mem_req.we        = 1'b1;
              top_next          = top_inc;
              gen_result.status = STATUS_OK;
              gen_result.depth  = DEPTH_OUT_W'(top_inc);
            end
          end else if (empty) begin
            gen_result.status = STATUS_UNDERFLOW;
          end else begin
            mem_req.re = 1'b1;
            top_next   = top_dec;
          end
        end
      end
      ST_READ: begin
        // top already points at the popped entry
        gen_valid           = 1'b1;
        gen_result.expected = expected;
        gen_result.status   = (expected == presented) ? STATUS_OK : STATUS_MISMATCH;
      end
      default: ;
    endcase
  end

  // state, counter and stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      call_count <= '0;
      top        <= '0;
    end else begin
      state <= state_next;
      top   <= top_next;
      if (accept && is_push) begin
        call_count <= count_inc;
      end
    end
  end

  // presented canary waits for the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      presented <= in_ch.presented_canary;
    end
  end

  // output register with a skid word behind it
  assign out_free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        out_valid  <= 1'b1;
        hold_valid <= gen_valid;
      end else begin
        out_valid  <= gen_valid;
      end
    end else if (gen_valid) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid) begin
        out_data <= hold_data;
        if (gen_valid) begin
          hold_data <= gen_result;
        end
      end else if (gen_valid) begin
        out_data <= gen_result;
      end
    end else if (gen_valid) begin
      hold_data <= gen_result;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_data.status;
  assign out_ch.canary_out   = out_data.canary;
  assign out_ch.expected_out = out_data.expected;
  assign out_ch.depth_out    = out_data.depth;

  // checks
  `CSS_ASSERT_ALWAYS(a_top_in_range, top <= CNT_W'(STACK_DEPTH), "stack pointer beyond depth")
  `CSS_ASSERT_SAME(a_skid_behind_out, hold_valid, out_valid, "skid word without output word")
  `CSS_ASSERT_NEXT(a_pop_reads, !rst && accept && !is_push && !empty, state == ST_READ,
                   "pop did not wait for memory read")
  `CSS_ASSERT_NEXT(a_push_grows, !rst && accept && is_push && !full,
                   top == $past(top) + CNT_W'(1), "push did not grow the stack")

endmodule

>>> hdl/canary_shadow_stack_unit.sv
// Shadow stack for per-call canaries, one 1024-entry memory of encrypted entries.
// Channels: in_ch takes command words (push or check), out_ch returns one result
// word per command; both are valid/ready, a word moves when valid and ready are high.
// Configuration: write_enable with reg_index 0 writes seed, 1 writes cookie; write
// only while no command is in flight.
// Push: the result is registered at the accepting edge and shows on out_ch the next
// cycle unless out_ch stalls. A new command may follow while no skid word is held.
// Check that pops an entry: the result waits in ST_READ for the registered read data
// of the entry memory; the input is not ready during the read cycle.
// Check on an empty stack: the result is formed at acceptance, like a push.
// A stalled receiver: the output register plus one skid word buffer results; the
// input stops taking commands once the skid word is in use.
// Reset (rst, synchronous): clears seed, cookie, call counter, stack pointer and
// the result buffers; the entry memory is not cleared, no clearing pass is needed.
`timescale 1ns / 1ps

module canary_shadow_stack_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          write_enable,
  input  logic [css_pkg::REG_IDX_W-1:0] reg_index,
  input  logic [css_pkg::DATA_W-1:0]    write_data,
  css_in_if.sink                        in_ch,
  css_out_if.source                     out_ch
);
  import css_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  // control and result path
  css_core u_core (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata)
  );

  // encrypted entry store
  css_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> verif/canary_shadow_stack_unit_test.sv
// self-checking testbench for the canary shadow stack unit
`timescale 1ns / 1ps

module canary_shadow_stack_unit_test;
  import css_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;

  // predicted stack, counter and registers; queue of result words still owed
  class canary_ledger;
    logic [DATA_W-1:0] seed_reg = '0;
    logic [DATA_W-1:0] cookie_reg = '0;
    logic [DATA_W-1:0] call_count = '0;
    logic [DATA_W-1:0] frames [STACK_DEPTH];
    int unsigned depth = 0;
    result_t owed_results [$];
    int unsigned failures = 0;

    function void set_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_SEED:   seed_reg = value;
        REG_COOKIE: cookie_reg = value;
        default:    ;
      endcase
    endfunction

    // canary that a well-formed check would present for the top frame
    function logic [DATA_W-1:0] top_canary();
      if (depth == 0) return '0;
      return frames[depth-1] ^ cookie_reg;
    endfunction

    // predict the result word of an accepted command word
    function void record_command(logic cmd, logic [DATA_W-1:0] ident,
                                 logic [DATA_W-1:0] presented);
      result_t want;
      want.status   = STATUS_OK;
      want.canary   = '0;
      want.expected = '0;
      if (cmd == CMD_PUSH) begin
        call_count += 1;
        want.canary = seed_reg ^ ident ^ call_count;
        if (depth >= STACK_DEPTH) begin
          want.status = STATUS_OVERFLOW;
        end else begin
          frames[depth] = want.canary ^ cookie_reg;
          depth++;
        end
      end else if (depth == 0) begin
        want.status = STATUS_UNDERFLOW;
      end else begin
        depth--;
        want.expected = frames[depth] ^ cookie_reg;
        if (want.expected != presented) want.status = STATUS_MISMATCH;
      end
      want.depth = depth[DEPTH_OUT_W-1:0];
      owed_results.push_back(want);
    endfunction

    function void report_field(string field, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        failures++;
      end
    endfunction

    // compare an accepted result word with the oldest prediction
    function void compare_result(result_t got);
      result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t ns: result word with none expected, expected none, actual %h",
                 $time, got);
        failures++;
        return;
      end
      want = owed_results.pop_front();
      report_field("status", want.status, got.status);
      report_field("canary_out", want.canary, got.canary);
      report_field("expected_out", want.expected, got.expected);
      report_field("depth_out", want.depth, got.depth);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0] write_data;

  css_in_if  command_ch ();
  css_out_if result_ch ();

  canary_ledger ledger = new();
  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 73;
  int unsigned stall_request = 0;

  canary_shadow_stack_unit dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_ch        (command_ch),
    .out_ch       (result_ch)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] random64();
    return {$urandom(), $urandom()};
  endfunction

  // offer one command word and record it once it is taken
  task automatic offer_command(input logic cmd, input logic [DATA_W-1:0] ident,
                               input logic [DATA_W-1:0] presented);
    while ($urandom_range(99) < send_idle_pct) begin
      command_ch.valid <= 1'b0;
      @(posedge clk);
    end
    command_ch.valid            <= 1'b1;
    command_ch.command          <= cmd;
    command_ch.func_ident       <= ident;
    command_ch.presented_canary <= presented;
    @(posedge clk);
    while (!command_ch.ready) @(posedge clk);
    ledger.record_command(cmd, ident, presented);
  endtask

  task automatic push_frame();
    logic [DATA_W-1:0] ident;
    int unsigned pick;
    pick = $urandom_range(99);
    ident = random64();
    if (pick < 3) ident = '0;
    else if (pick < 6) ident = ALL_ONES;
    offer_command(CMD_PUSH, ident, random64());
  endtask

  // mostly the right canary, some with one bit flipped, some random
  task automatic check_frame();
    logic [DATA_W-1:0] presented;
    int unsigned pick;
    pick = $urandom_range(99);
    presented = ledger.top_canary();
    if (pick >= 94) presented = random64();
    else if (pick >= 84) presented ^= 64'd1 << $urandom_range(63);
    offer_command(CMD_CHECK, random64(), presented);
  endtask

  // random call/return traffic, pulled back down at or above depth_cap
  task automatic random_walk(input int unsigned count, input int unsigned push_pct,
                             input int unsigned depth_cap);
    int unsigned pct;
    for (int unsigned i = 0; i < count; i++) begin
      pct = (ledger.depth >= depth_cap) ? 25 : push_pct;
      if ($urandom_range(99) < pct) push_frame();
      else check_frame();
    end
  endtask

  // stop offering until every result word is back, then let the block settle
  task automatic wait_until_drained();
    command_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    @(posedge clk);
    ledger.set_register(idx, value);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // result side: check accepted words, then pick ready for the next cycle
  initial begin
    int unsigned hold_left;
    result_t observed;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        observed.status   = result_ch.status;
        observed.canary   = result_ch.canary_out;
        observed.expected = result_ch.expected_out;
        observed.depth    = result_ch.depth_out;
        ledger.compare_result(observed);
      end
      if (stall_request != 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((command_ch.valid && command_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // stimulus
  initial begin
    rst                         <= 1'b1;
    write_enable                <= 1'b0;
    reg_index                   <= REG_SEED;
    write_data                  <= '0;
    command_ch.valid            <= 1'b0;
    command_ch.command          <= CMD_PUSH;
    command_ch.func_ident       <= '0;
    command_ch.presented_canary <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset registers, underflow, match and mismatch
    offer_command(CMD_CHECK, ALL_ONES, ALL_ONES);
    offer_command(CMD_PUSH, '0, ALL_ONES);
    offer_command(CMD_PUSH, ALL_ONES, '0);
    offer_command(CMD_CHECK, '0, ledger.top_canary());
    offer_command(CMD_CHECK, ALL_ONES, ledger.top_canary() ^ {1'b1, 63'd0});
    offer_command(CMD_CHECK, '0, '0);
    wait_until_drained();

    // directed: extreme seed and cookie, cookie changed under stored entries
    write_register(REG_SEED, ALL_ONES);
    write_register(REG_COOKIE, ALL_ONES);
    offer_command(CMD_PUSH, 64'h0123_4567_89ab_cdef, '0);
    offer_command(CMD_PUSH, '0, '0);
    wait_until_drained();
    write_register(REG_COOKIE, '0);
    offer_command(CMD_CHECK, '0, ledger.top_canary());
    offer_command(CMD_CHECK, ALL_ONES, '0);
    wait_until_drained();

    // fill to full depth and push past it, with a long result stall partway in
    write_register(REG_SEED, random64());
    write_register(REG_COOKIE, random64());
    while (ledger.depth < STACK_DEPTH) begin
      if (ledger.depth == 200) stall_request = HOLD_CYCLES;
      push_frame();
    end
    offer_command(CMD_PUSH, ALL_ONES, ALL_ONES);
    offer_command(CMD_PUSH, '0, '0);
    random_walk(100, 60, STACK_DEPTH + 1);
    wait_until_drained();

    // sender mostly idle, receiver mostly ready; the walks pull the stack down
    send_idle_pct = 73;
    recv_idle_pct = 16;
    write_register(REG_SEED, random64());
    write_register(REG_COOKIE, '0);
    random_walk(150, 55, 12);
    wait_until_drained();
    write_register(REG_COOKIE, ALL_ONES);
    random_walk(150, 55, 12);
    wait_until_drained();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(REG_SEED, '0);
    write_register(REG_COOKIE, random64());
    random_walk(300, 55, 12);
    wait_until_drained();

    if (ledger.failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
